>>> rtl/smia_pkg.sv
package smia_pkg;

  // Largest matrix order handled by the storage and the permutation table.
  localparam int unsigned MaxOrder  = 4;
  localparam int unsigned StoreDep  = MaxOrder * MaxOrder;
  localparam int unsigned NumPerms  = 24;
  localparam int unsigned AccW      = 68;  // exact determinant, signed
  localparam int unsigned ProdW     = 61;  // magnitude of one Leibniz product
  localparam int unsigned NumW      = 75;  // rounded-division numerator
  localparam int unsigned RemW      = 70;
  localparam int unsigned DivSteps  = NumW;

  typedef struct packed {
    logic            odd;
    logic [3:0][1:0] p;
  } perm_t;

  // Command word from the sequencer to the datapath.
  typedef struct packed {
    logic       wr_en;
    logic [3:0] wr_addr;
    logic       rd_en;
    logic [3:0] rd_addr;
    logic       prod_init;
    logic       prod_mul;
    logic       acc_clr;
    logic       acc_add;
    logic       acc_odd;
    logic       det_latch;
    logic       div_load;
    logic       sign_flip;
    logic       div_step;
    logic       out_load;
    logic       out_zero;
    logic [1:0] row;
    logic [1:0] col;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic singular;
  } status_t;

  function automatic perm_t mk_perm(input logic [1:0] a, input logic [1:0] b,
                                    input logic [1:0] c, input logic [1:0] d,
                                    input logic odd);
    perm_t r;
    r.p[0] = a;
    r.p[1] = b;
    r.p[2] = c;
    r.p[3] = d;
    r.odd  = odd;
    return r;
  endfunction

  // All permutations of four positions with their inversion parity.
  function automatic perm_t perm_entry(input logic [4:0] idx);
    perm_t r;
    case (idx)
      5'd0:    r = mk_perm(2'd0, 2'd1, 2'd2, 2'd3, 1'b0);
      5'd1:    r = mk_perm(2'd0, 2'd1, 2'd3, 2'd2, 1'b1);
      5'd2:    r = mk_perm(2'd0, 2'd2, 2'd1, 2'd3, 1'b1);
      5'd3:    r = mk_perm(2'd0, 2'd2, 2'd3, 2'd1, 1'b0);
      5'd4:    r = mk_perm(2'd0, 2'd3, 2'd1, 2'd2, 1'b0);
      5'd5:    r = mk_perm(2'd0, 2'd3, 2'd2, 2'd1, 1'b1);
      5'd6:    r = mk_perm(2'd1, 2'd0, 2'd2, 2'd3, 1'b1);
      5'd7:    r = mk_perm(2'd1, 2'd0, 2'd3, 2'd2, 1'b0);
      5'd8:    r = mk_perm(2'd1, 2'd2, 2'd0, 2'd3, 1'b0);
      5'd9:    r = mk_perm(2'd1, 2'd2, 2'd3, 2'd0, 1'b1);
      5'd10:   r = mk_perm(2'd1, 2'd3, 2'd0, 2'd2, 1'b1);
      5'd11:   r = mk_perm(2'd1, 2'd3, 2'd2, 2'd0, 1'b0);
      5'd12:   r = mk_perm(2'd2, 2'd0, 2'd1, 2'd3, 1'b0);
      5'd13:   r = mk_perm(2'd2, 2'd0, 2'd3, 2'd1, 1'b1);
      5'd14:   r = mk_perm(2'd2, 2'd1, 2'd0, 2'd3, 1'b1);
      5'd15:   r = mk_perm(2'd2, 2'd1, 2'd3, 2'd0, 1'b0);
      5'd16:   r = mk_perm(2'd2, 2'd3, 2'd0, 2'd1, 1'b0);
      5'd17:   r = mk_perm(2'd2, 2'd3, 2'd1, 2'd0, 1'b1);
      5'd18:   r = mk_perm(2'd3, 2'd0, 2'd1, 2'd2, 1'b1);
      5'd19:   r = mk_perm(2'd3, 2'd0, 2'd2, 2'd1, 1'b0);
      5'd20:   r = mk_perm(2'd3, 2'd1, 2'd0, 2'd2, 1'b0);
      5'd21:   r = mk_perm(2'd3, 2'd1, 2'd2, 2'd0, 1'b1);
      5'd22:   r = mk_perm(2'd3, 2'd2, 2'd0, 2'd1, 1'b1);
      5'd23:   r = mk_perm(2'd3, 2'd2, 2'd1, 2'd0, 1'b0);
      default: r = mk_perm(2'd0, 2'd1, 2'd2, 2'd3, 1'b0);
    endcase
    return r;
  endfunction

endpackage

>>> rtl/smia_ctrl.sv
module smia_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         order_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  smia_pkg::status_t  sts_i,
  output smia_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_PERM, ST_TERM, ST_MUL, ST_ACC, ST_FIN, ST_CSTART, ST_DIV, ST_EMIT
  } state_e;

  state_e      state_q, state_d;
  logic [4:0]  load_cnt_q, load_cnt_d;
  logic [4:0]  perm_q, perm_d;
  logic [2:0]  term_q, term_d;
  logic [2:0]  k_q, k_d;
  logic        is_det_q, is_det_d;
  logic [1:0]  row_q, row_d;
  logic [1:0]  col_q, col_d;
  logic [6:0]  div_cnt_q, div_cnt_d;

  smia_pkg::perm_t perm;
  logic        perm_ok;
  logic [4:0]  cnt_inc;
  logic [4:0]  order_sq;
  logic [2:0]  ri;
  logic [2:0]  cj;
  logic [5:0]  addr_full;
  logic        last_pos;
  logic        perm_end;

  assign perm     = smia_pkg::perm_entry(perm_q);
  assign cnt_inc  = load_cnt_q + 5'd1;
  assign order_sq = {2'b0, order_i} * {2'b0, order_i};
  assign perm_end = (perm_q == 5'(smia_pkg::NumPerms - 1));
  assign last_pos = ({1'b0, row_q} == order_i - 3'd1) && ({1'b0, col_q} == order_i - 3'd1);

  // Only permutations that leave positions k and above in place belong to order k.
  always_comb begin
    perm_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) >= k_q) && (perm.p[i] != 2'(i))) begin
        perm_ok = 1'b0;
      end
    end
  end

  // Element address: a cofactor drops row col_q and column row_q of the matrix.
  always_comb begin
    ri = {1'b0, term_q[1:0]};
    cj = {1'b0, perm.p[term_q[1:0]]};
    if (!is_det_q && (term_q[1:0] >= col_q)) begin
      ri = ri + 3'd1;
    end
    if (!is_det_q && (perm.p[term_q[1:0]] >= row_q)) begin
      cj = cj + 3'd1;
    end
    addr_full = ({3'b0, ri} * {3'b0, order_i}) + {3'b0, cj};
  end

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    perm_d     = perm_q;
    term_d     = term_q;
    k_d        = k_q;
    is_det_d   = is_det_q;
    row_d      = row_q;
    col_d      = col_q;
    div_cnt_d  = div_cnt_q;
    cmd_o      = '0;
    cmd_o.wr_addr   = load_cnt_q[3:0];
    cmd_o.rd_addr   = addr_full[3:0];
    cmd_o.acc_odd   = perm.odd;
    cmd_o.sign_flip = row_q[0] ^ col_q[0];
    cmd_o.row       = row_q;
    cmd_o.col       = col_q;
    cmd_o.last      = last_pos;
    cmd_o.out_zero  = sts_i.singular;
    in_ready_o = (state_q == ST_LOAD);
    case (state_q)
      ST_LOAD: begin
        if (in_valid_i) begin
          cmd_o.wr_en = (load_cnt_q < 5'(smia_pkg::StoreDep));
          load_cnt_d  = cnt_inc;
          if (cnt_inc >= order_sq) begin
            load_cnt_d    = '0;
            k_d           = order_i;
            is_det_d      = 1'b1;
            perm_d        = '0;
            cmd_o.acc_clr = 1'b1;
            state_d       = ST_PERM;
          end
        end
      end
      ST_PERM: begin
        if (perm_ok) begin
          cmd_o.prod_init = 1'b1;
          term_d          = '0;
          state_d         = ST_TERM;
        end else if (perm_end) begin
          state_d = ST_FIN;
        end else begin
          perm_d = perm_q + 5'd1;
        end
      end
      ST_TERM: begin
        if (term_q == k_q) begin
          state_d = ST_ACC;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.prod_mul = 1'b1;
        term_d         = term_q + 3'd1;
        state_d        = ST_TERM;
      end
      ST_ACC: begin
        cmd_o.acc_add = 1'b1;
        if (perm_end) begin
          state_d = ST_FIN;
        end else begin
          perm_d  = perm_q + 5'd1;
          state_d = ST_PERM;
        end
      end
      ST_FIN: begin
        if (is_det_q) begin
          cmd_o.det_latch = 1'b1;
          row_d           = '0;
          col_d           = '0;
          state_d         = ST_CSTART;
        end else begin
          cmd_o.div_load = 1'b1;
          div_cnt_d      = '0;
          state_d        = ST_DIV;
        end
      end
      ST_CSTART: begin
        if (sts_i.singular) begin
          state_d = ST_EMIT;
        end else begin
          k_d           = order_i - 3'd1;
          is_det_d      = 1'b0;
          perm_d        = '0;
          cmd_o.acc_clr = 1'b1;
          state_d       = ST_PERM;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (div_cnt_q == 7'(smia_pkg::DivSteps - 1)) begin
          state_d = ST_EMIT;
        end else begin
          div_cnt_d = div_cnt_q + 7'd1;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (last_pos) begin
            state_d = ST_LOAD;
          end else begin
            if ({1'b0, col_q} == order_i - 3'd1) begin
              col_d = '0;
              row_d = row_q + 2'd1;
            end else begin
              col_d = col_q + 2'd1;
            end
            state_d = ST_CSTART;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      perm_q     <= '0;
      term_q     <= '0;
      k_q        <= '0;
      is_det_q   <= 1'b0;
      row_q      <= '0;
      col_q      <= '0;
      div_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      perm_q     <= perm_d;
      term_q     <= term_d;
      k_q        <= k_d;
      is_det_q   <= is_det_d;
      row_q      <= row_d;
      col_q      <= col_d;
      div_cnt_q  <= div_cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("result loaded while output register busy");
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> (term_q < k_q))
    else $error("element read past the permutation length");
  a_div_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && div_cnt_q == 7'(smia_pkg::DivSteps - 1)) |=> state_q == ST_EMIT)
    else $error("division did not finish into emit");
`endif

endmodule

>>> rtl/smia_dp.sv
module smia_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         order_i,
  input  smia_pkg::cmd_t     cmd_i,
  output smia_pkg::status_t  sts_o,
  input  logic signed [15:0] element_value_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic signed [31:0] inverse_entry_o,
  output logic [1:0]         entry_row_o,
  output logic [1:0]         entry_col_o,
  output logic signed [47:0] determinant_value_o,
  output logic               singular_flag_o,
  output logic               last_entry_o
);

  localparam int unsigned AccW  = smia_pkg::AccW;
  localparam int unsigned ProdW = smia_pkg::ProdW;
  localparam int unsigned NumW  = smia_pkg::NumW;
  localparam int unsigned RemW  = smia_pkg::RemW;

  logic [15:0]       mem_q [smia_pkg::StoreDep];
  logic [15:0]       rdata_q;
  logic [ProdW-1:0]  prod_q;
  logic              pneg_q;
  logic [AccW-1:0]   acc_q;
  logic [AccW-1:0]   dmag_q;
  logic              dneg_q;
  logic              sing_q;
  logic [47:0]       dout_q;
  logic [NumW-1:0]   n2_q;
  logic [RemW-1:0]   rem_q;
  logic [NumW-1:0]   quo_q;
  logic              eneg_q;
  logic              out_valid_q;
  logic [31:0]       entry_q;
  logic [1:0]        row_q;
  logic [1:0]        col_q;
  logic              last_q;
  logic [47:0]       det_out_q;
  logic              sing_out_q;

  logic [15:0]       mag;
  logic [76:0]       prod_full;
  logic [AccW-1:0]   acc_term;
  logic [AccW-1:0]   acc_mag;
  logic              acc_neg;
  logic [AccW:0]     dround;
  logic [AccW:0]     dlim;
  logic [AccW:0]     dsat;
  logic              dsing;
  logic [RemW-1:0]   rem_sh;
  logic [RemW-1:0]   d2;
  logic              ge;
  logic [NumW-1:0]   elim;
  logic [NumW-1:0]   esat;
  logic [31:0]       entry_d;

  assign mag       = rdata_q[15] ? 16'(-rdata_q) : rdata_q;
  assign prod_full = {16'b0, prod_q} * {61'b0, mag};
  assign acc_term  = {{(AccW-ProdW){1'b0}}, prod_q};
  assign acc_neg   = acc_q[AccW-1];
  assign acc_mag   = acc_neg ? -acc_q : acc_q;

  // Determinant to Q40.8: round half away from zero, then clamp.
  always_comb begin
    case (order_i)
      3'd2:    dround = ({1'b0, acc_mag} + (AccW+1)'(1 << 7))  >> 8;
      3'd3:    dround = ({1'b0, acc_mag} + (AccW+1)'(1 << 15)) >> 16;
      3'd4:    dround = ({1'b0, acc_mag} + (AccW+1)'(1 << 23)) >> 24;
      default: dround = {1'b0, acc_mag};
    endcase
    dlim = acc_neg ? (AccW+1)'(48'h8000_0000_0000) : (AccW+1)'(48'h7FFF_FFFF_FFFF);
    dsat = (dround > dlim) ? dlim : dround;
    case (order_i)
      3'd3:    dsing = acc_mag < AccW'(1 << 4);
      3'd4:    dsing = acc_mag < AccW'(1 << 12);
      default: dsing = (acc_mag == '0);
    endcase
  end

  assign d2     = {1'b0, dmag_q, 1'b0};
  assign rem_sh = {rem_q[RemW-2:0], n2_q[NumW-1]};
  assign ge     = rem_sh >= d2;
  assign elim   = eneg_q ? NumW'(33'h1_0000_0000 >> 1) : NumW'(32'h7FFF_FFFF);
  assign esat   = (quo_q > elim) ? elim : quo_q;
  assign entry_d = cmd_i.out_zero ? 32'd0 : (eneg_q ? -esat[31:0] : esat[31:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[cmd_i.wr_addr] <= element_value_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[cmd_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_init) begin
      prod_q <= ProdW'(1);
      pneg_q <= 1'b0;
    end else if (cmd_i.prod_mul) begin
      prod_q <= prod_full[ProdW-1:0];
      pneg_q <= pneg_q ^ rdata_q[15];
    end
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= (cmd_i.acc_odd ^ pneg_q) ? acc_q - acc_term : acc_q + acc_term;
    end
    if (cmd_i.det_latch) begin
      dmag_q <= acc_mag;
      dneg_q <= acc_neg;
      dout_q <= acc_neg ? -dsat[47:0] : dsat[47:0];
    end
    if (cmd_i.div_load) begin
      n2_q   <= ({{(NumW-48){1'b0}}, acc_mag[47:0]} << 25) +
                {{(NumW-AccW){1'b0}}, dmag_q};
      rem_q  <= '0;
      quo_q  <= '0;
      eneg_q <= acc_neg ^ cmd_i.sign_flip ^ dneg_q;
    end else if (cmd_i.div_step) begin
      n2_q  <= {n2_q[NumW-2:0], 1'b0};
      rem_q <= ge ? rem_sh - d2 : rem_sh;
      quo_q <= {quo_q[NumW-2:0], ge};
    end
    // The whole word is captured here so that a stalled word keeps its
    // determinant and flag while the next matrix is already being worked on.
    if (cmd_i.out_load) begin
      entry_q    <= entry_d;
      row_q      <= cmd_i.row;
      col_q      <= cmd_i.col;
      last_q     <= cmd_i.last;
      det_out_q  <= dout_q;
      sing_out_q <= sing_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.det_latch) begin
        sing_q <= dsing;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.singular = sing_q;

  assign out_valid_o         = out_valid_q;
  assign inverse_entry_o     = entry_q;
  assign entry_row_o         = row_q;
  assign entry_col_o         = col_q;
  assign determinant_value_o = det_out_q;
  assign singular_flag_o     = sing_out_q;
  assign last_entry_o        = last_q;

endmodule

>>> rtl/small_matrix_inverse_adjugate.sv
// Channel   Direction  Handshake                  Word
// in        input      in_valid_i / in_ready_o    element_value_i (Q8.8, row-major)
// out       output     out_valid_o / out_ready_i  inverse_entry_o, entry_row_o,
//                                                 entry_col_o, determinant_value_o,
//                                                 singular_flag_o, last_entry_o
// cfg       input      cfg_we_i                   cfg_wdata_i (matrix order)
//
// Words are loaded while the input is ready. For an order-4 matrix the determinant
// sums 24 permutations on the shared multiplier, and each inverse entry then takes
// a cofactor walk and a restoring divider. A singular matrix skips the cofactors.
// One matrix is in work at a time; the input is ready only while loading.
// A stalled output word holds the sequencer in its emit step without losing work.
// Reset is asynchronous and active low; the element store needs no clearing.
module small_matrix_inverse_adjugate (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] element_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] inverse_entry_o,
  output logic [1:0]         entry_row_o,
  output logic [1:0]         entry_col_o,
  output logic signed [47:0] determinant_value_o,
  output logic               singular_flag_o,
  output logic               last_entry_o
);

  logic [2:0]        matrix_size_q;
  logic [2:0]        order;
  smia_pkg::cmd_t    cmd;
  smia_pkg::status_t sts;

  // The order register resets to the largest order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_size_q <= 3'(smia_pkg::MaxOrder);
    end else if (cfg_we_i) begin
      matrix_size_q <= cfg_wdata_i;
    end
  end

  // An order of zero behaves as one, and one above the maximum behaves as the maximum.
  always_comb begin
    if (matrix_size_q == 3'd0) begin
      order = 3'd1;
    end else if (matrix_size_q > 3'(smia_pkg::MaxOrder)) begin
      order = 3'(smia_pkg::MaxOrder);
    end else begin
      order = matrix_size_q;
    end
  end

  smia_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .order_i    (order),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  smia_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .order_i             (order),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .element_value_i     (element_value_i),
    .out_ready_i         (out_ready_i),
    .out_valid_o         (out_valid_o),
    .inverse_entry_o     (inverse_entry_o),
    .entry_row_o         (entry_row_o),
    .entry_col_o         (entry_col_o),
    .determinant_value_o (determinant_value_o),
    .singular_flag_o     (singular_flag_o),
    .last_entry_o        (last_entry_o)
  );

endmodule

>>> test/tb_small_matrix_inverse_adjugate.sv
`timescale 1ns / 1ps

// Self-checking bench for the adjugate matrix inverse. Every accepted element word
// feeds a local model of the loader. When a matrix is complete, the model computes
// the exact determinant and cofactors with wide integer math. It then queues the
// inverse entries that the block must return, in order. A monitor pops one
// expectation per accepted output word and compares every field.
module tb_small_matrix_inverse_adjugate;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [31:0] inv;
    logic [1:0]  row;
    logic [1:0]  col;
    logic [47:0] det;
    logic        sing;
    logic        last;
  } entry_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [2:0]         cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] element_value_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] inverse_entry_o;
  logic [1:0]         entry_row_o;
  logic [1:0]         entry_col_o;
  logic signed [47:0] determinant_value_o;
  logic               singular_flag_o;
  logic               last_entry_o;

  // Local copy of the block state.
  logic [2:0]         order_reg;
  logic signed [15:0] elem_store [16];
  int unsigned        fill_count;

  entry_t inverse_q[$];
  int     err_cnt = 0;
  bit     quiet = 1'b0;  // no idling on either side in the last part of the run
  int     out_stall = 0;

  always #4 clk_i = ~clk_i;

  small_matrix_inverse_adjugate uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .element_value_i     (element_value_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .inverse_entry_o     (inverse_entry_o),
    .entry_row_o         (entry_row_o),
    .entry_col_o         (entry_col_o),
    .determinant_value_o (determinant_value_o),
    .singular_flag_o     (singular_flag_o),
    .last_entry_o        (last_entry_o)
  );

  // Exact determinant by expansion along the first row. The value equals the
  // permutation sum, since both are exact.
  function automatic wide_t exact_det(int k, wide_t m [4][4]);
    wide_t sub [4][4];
    wide_t acc;
    int    cc;
    if (k == 0) return 1;
    acc = 0;
    for (int j = 0; j < k; j++) begin
      for (int a = 0; a < 4; a++)
        for (int b = 0; b < 4; b++) sub[a][b] = 0;
      for (int a = 1; a < k; a++) begin
        cc = 0;
        for (int b = 0; b < k; b++) begin
          if (b != j) begin
            sub[a-1][cc] = m[a][b];
            cc++;
          end
        end
      end
      if (j % 2 == 0) acc = acc + m[0][j] * exact_det(k - 1, sub);
      else acc = acc - m[0][j] * exact_det(k - 1, sub);
    end
    return acc;
  endfunction

  // Consumes one element word and queues the inverse entries once the matrix is full.
  task automatic inverse_model(input logic signed [15:0] v);
    wide_t  mat [4][4];
    wide_t  minor_m [4][4];
    wide_t  det, dmag, cof, q, lim;
    bit     dneg, sing, neg;
    int     n, s;
    entry_t e;
    n = (order_reg == 0) ? 1 : (order_reg > 4) ? 4 : order_reg;
    if (fill_count < 16) elem_store[fill_count] = v;
    fill_count++;
    if (fill_count < n * n) return;
    fill_count = 0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        mat[i][j] = (i < n && j < n) ? wide_t'(elem_store[i*n+j]) : 0;
    det  = exact_det(n, mat);
    dneg = det < 0;
    dmag = dneg ? -det : det;
    if (8 * n > 20) sing = dmag < (wide_t'(1) <<< (8 * n - 20));
    else sing = dmag == 0;
    // Determinant back to Q40.8, rounded half away from zero, then saturated.
    s = 8 * (n - 1);
    q = (s > 0) ? ((dmag + (wide_t'(1) <<< (s - 1))) >>> s) : dmag;
    lim = dneg ? (wide_t'(1) <<< 47) : ((wide_t'(1) <<< 47) - 1);
    if (q > lim) q = lim;
    if (dneg) q = -q;
    e.det  = q[47:0];
    e.sing = sing;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        e.inv = '0;
        if (!sing) begin
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) minor_m[i][j] = 0;
          for (int i = 0; i < n - 1; i++)
            for (int j = 0; j < n - 1; j++)
              minor_m[i][j] = mat[i < c ? i : i + 1][j < r ? j : j + 1];
          cof = exact_det(n - 1, minor_m);
          neg = (cof < 0) ^ ((r + c) % 2) ^ dneg;
          if (cof < 0) cof = -cof;
          cof = cof <<< 24;
          q = (2 * cof + dmag) / (2 * dmag);
          lim = neg ? (wide_t'(1) <<< 31) : ((wide_t'(1) <<< 31) - 1);
          if (q > lim) q = lim;
          if (neg) q = -q;
          e.inv = q[31:0];
        end
        e.row  = r[1:0];
        e.col  = c[1:0];
        e.last = (r == n - 1) && (c == n - 1);
        inverse_q.push_back(e);
      end
    end
  endtask

  // Sends one element word, with a random gap in front of it now and then.
  task automatic send_word(input logic signed [15:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    element_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    inverse_model(v);
  endtask

  // Lets the block drain completely. A trailing partial load leaves it still
  // loading, so the settle time only has to cover the last computation.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic set_order(input logic [2:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    order_reg = v;
  endtask

  function automatic logic signed [15:0] rand_elem(int kind);
    case (kind)
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 1024) - 512);
      default: return 16'($urandom_range(0, 4) - 2);
    endcase
  endfunction

  // Order one covers the field extremes, the reciprocal and a zero (singular) word.
  task automatic test_order_one();
    set_order(3'd1);
    send_word(16'sh7FFF);
    send_word(-16'sh8000);
    send_word(16'sd0);
    send_word(16'sd1);
    send_word(-16'sd1);
    send_word(16'sd256);
    wait_idle();
  endtask

  // Order two with the identity and then a matrix of extreme elements.
  task automatic test_order_two();
    set_order(3'd2);
    send_word(16'sd256); send_word(16'sd0); send_word(16'sd0); send_word(16'sd256);
    send_word(-16'sh8000); send_word(16'sh7FFF);
    send_word(16'sh7FFF); send_word(-16'sh8000);
    wait_idle();
  endtask

  // An order of zero acts as one. Changing the order in the middle of a load keeps the count.
  task automatic test_order_edges();
    set_order(3'd0);
    send_word(16'sd512);
    wait_idle();
    set_order(3'd3);
    send_word(16'sd300); send_word(-16'sd77); send_word(16'sd12); send_word(16'sd900);
    wait_idle();
    set_order(3'd2);
    send_word(16'sd5);
    wait_idle();
  endtask

  // Random matrices of many orders: full-range, moderate, tiny or singular content.
  task automatic test_random();
    logic [2:0] orders [9] = '{3'd3, 3'd4, 3'd2, 3'd6, 3'd1, 3'd5, 3'd3, 3'd7, 3'd2};
    logic signed [15:0] m [16];
    int sent, n, kind, budget, pause_at;
    sent = 0;
    pause_at = $urandom_range(10, 60);
    for (int p = 0; p < 9; p++) begin
      if (p == 8) quiet = 1'b1;
      set_order(orders[p]);
      n = (orders[p] == 0) ? 1 : (orders[p] > 4) ? 4 : orders[p];
      budget = (n == 4) ? 16 : 18;
      for (int b = 0; b < budget; b += n * n) begin
        kind = $urandom_range(0, 9);
        for (int i = 0; i < n * n; i++)
          m[i] = rand_elem(kind < 5 ? 0 : kind < 8 ? 1 : 2);
        // Repeated row gives an exactly singular matrix.
        if (kind == 9 && n > 1)
          for (int j = 0; j < n; j++) m[n + j] = m[j];
        for (int i = 0; i < n * n; i++) begin
          send_word(m[i]);
          sent++;
          if (sent == pause_at) begin
            in_valid_i <= 1'b0;
            @(posedge clk_i);
            while (inverse_q.size() != 0) @(posedge clk_i);
          end
        end
      end
      wait_idle();
    end
  endtask

  // Result side stalls in random bursts.
  always @(posedge clk_i) begin
    if (quiet) begin
      out_ready_i <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall   <= out_stall - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall   <= $urandom_range(1, 15) - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Checks each accepted output word against the oldest expected entry.
  always @(posedge clk_i) begin
    entry_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual inv=%h", $time, inverse_entry_o);
        err_cnt++;
      end else begin
        x = inverse_q.pop_front();
        if (inverse_entry_o !== x.inv) begin
          $display("%0t: inverse_entry expected %h actual %h", $time, x.inv, inverse_entry_o);
          err_cnt++;
        end
        if (entry_row_o !== x.row || entry_col_o !== x.col) begin
          $display("%0t: position expected %0d,%0d actual %0d,%0d", $time, x.row, x.col,
                   entry_row_o, entry_col_o);
          err_cnt++;
        end
        if (determinant_value_o !== x.det) begin
          $display("%0t: determinant expected %h actual %h", $time, x.det,
                   determinant_value_o);
          err_cnt++;
        end
        if (singular_flag_o !== x.sing || last_entry_o !== x.last) begin
          $display("%0t: singular/last expected %b%b actual %b%b", $time, x.sing, x.last,
                   singular_flag_o, last_entry_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    order_reg  = 3'd4;
    fill_count = 0;
    for (int i = 0; i < 16; i++) elem_store[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_order_one();
    test_order_two();
    test_order_edges();
    test_random();
    if (err_cnt == 0 && inverse_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/smia_pkg.sv
rtl/smia_ctrl.sv
rtl/smia_dp.sv
rtl/small_matrix_inverse_adjugate.sv
test/tb_small_matrix_inverse_adjugate.sv
